[sv/mtg_pkg.sv]
// Shared types, constants and functions for the MT19937 generator.
// No dependencies; every other file refers to this package by scoped names.

package mtg_pkg;

   // State array geometry
   localparam int STATE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_DEPTH + 2);
   localparam int WORD_W       = 32;

   // Word index codes and address bounds
   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STATE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] IDX_SEEDED   = ADDR_W'(STATE_DEPTH);
   localparam logic [ADDR_W-1:0] IDX_NEVER    = ADDR_W'(STATE_DEPTH + 1);
   localparam logic [ADDR_W-1:0] FAR_FORWARD  = ADDR_W'(TWIST_OFFSET);
   localparam logic [ADDR_W-1:0] FAR_BACKWARD = ADDR_W'(STATE_DEPTH - TWIST_OFFSET);

   // Algorithm constants
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
   localparam int                MULT_W       = 17;
   localparam logic [MULT_W-1:0] SEED_MULT    = 17'd69069;

   // Request mode codes
   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_TWIST_LOAD,
      ST_TWIST_RD,
      ST_TWIST_WR,
      ST_DRAW_RD,
      ST_DRAW_OUT
   } mtg_state_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic              seed_load;
      logic              seed_default;
      logic              seed_step;
      logic              mem_we;
      logic              wr_twist;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_a_addr;
      logic [ADDR_W-1:0] rd_b_addr;
      logic              cur_load;
      logic              out_load;
   } mtg_ctl_type;

   // Neighbor word of the twist, wrapping at the end of the array
   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] k);
      return (k == LAST_ADDR) ? '0 : k + ADDR_W'(1);
   endfunction

   // Far word of the twist, TWIST_OFFSET ahead modulo the depth
   function automatic logic [ADDR_W-1:0] far_addr(input logic [ADDR_W-1:0] k);
      return (k < FAR_BACKWARD) ? k + FAR_FORWARD : k - FAR_BACKWARD;
   endfunction

   // One twisted word from the current, neighbor and far words
   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                    input logic [WORD_W-1:0] nxt,
                                                    input logic [WORD_W-1:0] far);
      logic [WORD_W-1:0] y;
      y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
      return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
   endfunction

   // Output tempering
   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

[sv/mtg_if.sv]
// Valid/ready channel interfaces for the MT19937 generator.
// Depends on mtg_pkg for the word width.

interface mtg_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [mtg_pkg::WORD_W-1:0] seed_value;

   modport source (output valid, output mode, output seed_value, input ready);
   modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mtg_pkg::WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

[sv/mtg_seq.sv]
// Sequencer of the MT19937 generator: seeding walk, twist walk and draw steps.
// Depends on mtg_pkg; drives mtg_dp through an mtg_ctl_type bundle.

module mtg_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output mtg_pkg::mtg_ctl_type ctl
);

   mtg_pkg::mtg_state_type          state_ff, state_in;
   logic [mtg_pkg::ADDR_W-1:0]      ctr_ff, ctr_in;
   logic [mtg_pkg::ADDR_W-1:0]      idx_ff, idx_in;
   logic                            draw_pend_ff, draw_pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            req_xfer;
   logic                            out_free;

   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtg_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_mode == mtg_pkg::MODE_SEED || idx_ff == mtg_pkg::IDX_NEVER) begin
                  state_in = mtg_pkg::ST_SEED;
               end else if (idx_ff == mtg_pkg::IDX_SEEDED) begin
                  state_in = mtg_pkg::ST_TWIST_LOAD;
               end else begin
                  state_in = mtg_pkg::ST_DRAW_RD;
               end
            end
         end
         mtg_pkg::ST_SEED: begin
            if (ctr_ff == mtg_pkg::LAST_ADDR) begin
               state_in = draw_pend_ff ? mtg_pkg::ST_TWIST_LOAD : mtg_pkg::ST_IDLE;
            end
         end
         mtg_pkg::ST_TWIST_LOAD: state_in = mtg_pkg::ST_TWIST_RD;
         mtg_pkg::ST_TWIST_RD:   state_in = mtg_pkg::ST_TWIST_WR;
         mtg_pkg::ST_TWIST_WR: begin
            state_in = (ctr_ff == mtg_pkg::LAST_ADDR) ? mtg_pkg::ST_DRAW_RD
                                                       : mtg_pkg::ST_TWIST_RD;
         end
         mtg_pkg::ST_DRAW_RD:    state_in = mtg_pkg::ST_DRAW_OUT;
         mtg_pkg::ST_DRAW_OUT: begin
            if (out_free) begin
               state_in = mtg_pkg::ST_IDLE;
            end
         end
         default: state_in = mtg_pkg::ST_IDLE;
      endcase
   end

   // Outputs and counter updates
   always_comb begin
      ctl          = '0;
      req_ready    = 1'b0;
      ctr_in       = ctr_ff;
      idx_in       = idx_ff;
      draw_pend_in = draw_pend_ff;
      case (state_ff)
         mtg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               ctr_in = '0;
               if (req_mode == mtg_pkg::MODE_SEED) begin
                  ctl.seed_load = 1'b1;
                  draw_pend_in  = 1'b0;
               end else if (idx_ff == mtg_pkg::IDX_NEVER) begin
                  ctl.seed_load    = 1'b1;
                  ctl.seed_default = 1'b1;
                  draw_pend_in     = 1'b1;
               end
            end
         end
         mtg_pkg::ST_SEED: begin
            ctl.mem_we    = 1'b1;
            ctl.wr_addr   = ctr_ff;
            ctl.seed_step = 1'b1;
            ctr_in        = ctr_ff + mtg_pkg::ADDR_W'(1);
            if (ctr_ff == mtg_pkg::LAST_ADDR) begin
               idx_in = mtg_pkg::IDX_SEEDED;
            end
         end
         mtg_pkg::ST_TWIST_LOAD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_a_addr = '0;
            ctr_in        = '0;
            draw_pend_in  = 1'b0;
         end
         mtg_pkg::ST_TWIST_RD: begin
            // Port A data still holds the old current word
            ctl.rd_en     = 1'b1;
            ctl.cur_load  = 1'b1;
            ctl.rd_a_addr = mtg_pkg::next_addr(ctr_ff);
            ctl.rd_b_addr = mtg_pkg::far_addr(ctr_ff);
         end
         mtg_pkg::ST_TWIST_WR: begin
            ctl.mem_we   = 1'b1;
            ctl.wr_twist = 1'b1;
            ctl.wr_addr  = ctr_ff;
            if (ctr_ff == mtg_pkg::LAST_ADDR) begin
               idx_in = '0;
            end else begin
               ctr_in = ctr_ff + mtg_pkg::ADDR_W'(1);
            end
         end
         mtg_pkg::ST_DRAW_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_a_addr = idx_ff;
         end
         mtg_pkg::ST_DRAW_OUT: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               idx_in       = idx_ff + mtg_pkg::ADDR_W'(1);
            end
         end
         default: ctl = '0;
      endcase
   end

   // Hold the result until the sink takes it
   always_comb begin
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::ST_IDLE;
         ctr_ff       <= '0;
         idx_ff       <= mtg_pkg::IDX_NEVER;
         draw_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         idx_ff       <= idx_in;
         draw_pend_ff <= draw_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/mtg_dp.sv]
// Datapath of the MT19937 generator: state memory, seed multiplier,
// twist unit and tempering output register. Depends on mtg_pkg.

module mtg_dp (
   input  logic                       clock,
   input  mtg_pkg::mtg_ctl_type       ctl,
   input  logic [mtg_pkg::WORD_W-1:0] seed_value,
   output logic [mtg_pkg::WORD_W-1:0] random_word
);

   localparam int PROD_W = mtg_pkg::WORD_W + mtg_pkg::MULT_W;

   logic [mtg_pkg::WORD_W-1:0] state_mem [mtg_pkg::STATE_DEPTH];
   logic [mtg_pkg::WORD_W-1:0] rd_a_ff, rd_b_ff, cur_ff, prod_ff, word_ff;
   logic [mtg_pkg::WORD_W-1:0] prod_in, wr_data;
   logic [PROD_W-1:0]          prod_full;

   // Advance the seed chain by one multiply modulo 2^32
   assign prod_full = PROD_W'(prod_ff) * PROD_W'(mtg_pkg::SEED_MULT);

   always_comb begin
      if (ctl.seed_load) begin
         prod_in = ctl.seed_default ? mtg_pkg::DEFAULT_SEED : seed_value;
      end else begin
         prod_in = prod_full[mtg_pkg::WORD_W-1:0];
      end
   end

   // Select seed word or twisted word for the write port
   assign wr_data = ctl.wr_twist ? mtg_pkg::twist_word(cur_ff, rd_a_ff, rd_b_ff) : prod_ff;

   always_ff @(posedge clock) begin
      if (ctl.mem_we) begin
         state_mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= state_mem[ctl.rd_a_addr];
         rd_b_ff <= state_mem[ctl.rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cur_load) begin
         cur_ff <= rd_a_ff;
      end
      if (ctl.seed_load || ctl.seed_step) begin
         prod_ff <= prod_in;
      end
      if (ctl.out_load) begin
         word_ff <= mtg_pkg::temper(rd_a_ff);
      end
   end

   assign random_word = word_ff;

endmodule

[sv/mersenne_twister_generator_top.sv]
// MT19937 pseudo-random generator with 69069 linear seeding, 624-word state
// held in one two-read, one-write memory. A seed transfer walks the whole
// memory through the seed multiplier, one word a cycle, and the block is
// not ready until the walk is done. A draw reads its word through the memory
// read port and the tempering register; the first draw after a seed and
// every 624th draw after it first twist the whole state, reading and then
// writing each word in turn through the twist unit. A draw before any seed
// first seeds with 4357. The block takes one item at a time; a finished
// word waits in the output register and does not block the next request
// transfer, but a following draw holds its word until the waiting one has
// been taken.
// Depends on mtg_pkg, mtg_if, mtg_seq and mtg_dp.

module mersenne_twister_generator_top (
   input logic      clock,
   input logic      reset,
   mtg_req_if.sink  req_chan,
   mtg_rsp_if.source rsp_chan
);

   mtg_pkg::mtg_ctl_type ctl;

   mtg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .ctl       (ctl)
   );

   mtg_dp u_dp (
      .clock       (clock),
      .ctl         (ctl),
      .seed_value  (req_chan.seed_value),
      .random_word (rsp_chan.random_word)
   );

endmodule

[sv/mtg_checker.sv]
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on mtg_pkg and on the top level's channel interfaces.

module mtg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [mtg_pkg::WORD_W-1:0] rsp_word
);

   // A stalled result keeps its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // One item at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A seed transfer gives no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == mtg_pkg::MODE_SEED && !rsp_valid |=> !rsp_valid)
      else $error("seed produced a result");

   // A draw needs the memory read before any result appears
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == mtg_pkg::MODE_DRAW |=> !$rose(rsp_valid))
      else $error("draw result appeared too early");

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.random_word)
);
